// ===== src/ccec_pkg.sv =====
// ----------------------------------------------------------------------------
// ccec_pkg
// Shared constants and types for the cyclic code encoder / corrector.
// ----------------------------------------------------------------------------
package ccec_pkg;

  localparam int CODE_LEN  = 15;
  localparam int DATA_LEN  = 11;
  localparam int CHECK_LEN = 4;

  localparam int GEN_W  = CHECK_LEN + 1;
  localparam int CNT_W  = $clog2(CODE_LEN);
  localparam int POS_W  = 4;
  localparam int ADDR_W = 3;
  localparam int APB_W  = 32;

  localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(19);

  // register index carried in paddr[2]
  localparam logic REG_GEN = 1'b0;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // control for one remainder chain
  typedef struct packed {
    logic clear;
    logic step;
    logic bit_in;
  } chain_ctrl_t;

endpackage

// ===== src/ccec_if.sv =====
// ----------------------------------------------------------------------------
// ccec_if
// Request channels of the cyclic code block: input and result.
// ----------------------------------------------------------------------------
interface ccec_in_if;
  import ccec_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [CODE_LEN-1:0] word_in;

  modport source (output valid, output op, output word_in, input ready);
  modport sink   (input valid, input op, input word_in, output ready);
endinterface

interface ccec_out_if;
  import ccec_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_LEN-1:0] codeword;
  logic [DATA_LEN-1:0] message_out;
  logic                error_found;
  logic [POS_W-1:0]    error_position;
  logic                uncorrectable;

  modport source (output valid, output codeword, output message_out, output error_found,
                  output error_position, output uncorrectable, input ready);
  modport sink   (input valid, input codeword, input message_out, input error_found,
                  input error_position, input uncorrectable, output ready);
endinterface

// ===== src/ccec_cell.sv =====
// ----------------------------------------------------------------------------
// ccec_cell
// One bit of the remainder register: takes its neighbor's bit, xors in the
// generator tap when the feedback fires.
// ----------------------------------------------------------------------------
module ccec_cell (
  input  logic                  clk,
  input  ccec_pkg::chain_ctrl_t ctrl,
  input  logic                  prev,
  input  logic                  fb,
  input  logic                  tap,
  output logic                  q
);
  import ccec_pkg::*;

  logic q_next;

  always_comb begin
    q_next = q;
    if (ctrl.clear) begin
      q_next = 1'b0;
    end else if (ctrl.step) begin
      q_next = prev ^ (fb & tap);
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== src/ccec_chain.sv =====
// ----------------------------------------------------------------------------
// ccec_chain
// Row of remainder cells: one bit of the dividend enters per step, MSB
// first, reduced at the true degree of the generator.
// ----------------------------------------------------------------------------
module ccec_chain (
  input  logic                        clk,
  input  ccec_pkg::chain_ctrl_t       ctrl,
  input  logic [ccec_pkg::GEN_W-1:0]  gen,
  output logic [ccec_pkg::CHECK_LEN-1:0] rem
);
  import ccec_pkg::*;

  logic [CHECK_LEN:0] shifted;
  logic               fb;

  assign shifted = {rem, ctrl.bit_in};

  // feedback is the shifted bit at the highest set generator bit
  always_comb begin
    fb = 1'b0;
    for (int j = 0; j <= CHECK_LEN; j++) begin
      if (gen[j]) begin
        fb = shifted[j];
      end
    end
  end

  for (genvar j = 0; j < CHECK_LEN; j++) begin : g_cell
    ccec_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .prev (shifted[j]),
      .fb   (fb),
      .tap  (gen[j]),
      .q    (rem[j])
    );
  end

endmodule

// ===== src/cyclic_code_encode_correct_core.sv =====
// ----------------------------------------------------------------------------
// cyclic_code_encode_correct_core
// Systematic cyclic code encoder and single-bit corrector.
// ----------------------------------------------------------------------------
// Steps: encode 15 division steps, one check, one output load; decode adds
//   up to 15 search steps. The output load waits for a free result register.
// Throughput: one request at a time, taken in idle; set by the bit-serial
//   remainder chain (one codeword bit per cycle, then one position per cycle).
// Reset: rst (synchronous) returns to idle, drops the result, and loads the
//   generator with x^4+x+1.
module cyclic_code_encode_correct_core (
  input  logic                        clk,
  input  logic                        rst,
  ccec_in_if.sink                     data_in,
  ccec_out_if.source                  data_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccec_pkg::ADDR_W-1:0] paddr,
  input  logic [ccec_pkg::APB_W-1:0]  pwdata,
  output logic [ccec_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);
  import ccec_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LEN - 1);

  state_t              state, state_next;
  logic [GEN_W-1:0]    gen;
  logic                op_q;
  logic [CODE_LEN-1:0] word;
  logic [CNT_W-1:0]    cnt;
  logic                found;
  logic                bad;
  logic [POS_W-1:0]    pos;
  logic                out_valid;

  logic                accept;
  logic                out_free;
  logic                match;
  logic                syn_zero;
  logic                load_out;
  chain_ctrl_t         syn_ctrl;
  chain_ctrl_t         pos_ctrl;
  logic [CHECK_LEN-1:0] syn_rem;
  logic [CHECK_LEN-1:0] pos_rem;

  // ---- configuration ----
  assign pready = 1'b1;
  assign prdata = APB_W'(gen);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= GEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GEN) begin
      gen <= pwdata[GEN_W-1:0];
    end
  end

  // ---- remainder chains: syndrome of the word, syndrome of x^cnt ----
  ccec_chain u_syn (
    .clk  (clk),
    .ctrl (syn_ctrl),
    .gen  (gen),
    .rem  (syn_rem)
  );

  ccec_chain u_pos (
    .clk  (clk),
    .ctrl (pos_ctrl),
    .gen  (gen),
    .rem  (pos_rem)
  );

  assign match    = (syn_rem == pos_rem);
  assign syn_zero = (syn_rem == '0);

  // ---- control ----
  assign data_in.ready = (state == ST_IDLE);
  assign accept        = data_in.valid && data_in.ready;
  assign out_free      = !out_valid || data_out.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (cnt == '0) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (op_q == OP_ENCODE || syn_zero) state_next = ST_FINISH;
        else                               state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (match || cnt == CNT_LAST) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    syn_ctrl.clear  = accept;
    syn_ctrl.step   = (state == ST_DIVIDE);
    syn_ctrl.bit_in = word[cnt];
    // x^0 enters on the last division step so x^0 mod g is ready at check
    pos_ctrl.clear  = accept;
    pos_ctrl.step   = (state == ST_DIVIDE) || (state == ST_SEARCH);
    pos_ctrl.bit_in = (state == ST_DIVIDE) && (cnt == '0);
    load_out        = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= data_in.op;
      found <= 1'b0;
      bad   <= 1'b0;
      pos   <= '0;
      cnt   <= CNT_LAST;
      if (data_in.op == OP_ENCODE) begin
        word <= {data_in.word_in[DATA_LEN-1:0], {CHECK_LEN{1'b0}}};
      end else begin
        word <= data_in.word_in;
      end
    end else begin
      case (state)
        ST_DIVIDE: begin
          if (cnt != '0) cnt <= cnt - 1'b1;
        end
        ST_CHECK: begin
          if (op_q == OP_ENCODE) begin
            word <= word ^ CODE_LEN'(syn_rem);
          end else if (!syn_zero) begin
            found <= 1'b1;
          end
        end
        ST_SEARCH: begin
          if (match) begin
            word <= word ^ (CODE_LEN'(1) << cnt);
            pos  <= POS_W'(cnt);
          end else if (cnt == CNT_LAST) begin
            bad <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (data_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      data_out.codeword       <= word;
      data_out.message_out    <= word[CODE_LEN-1:CHECK_LEN];
      data_out.error_found    <= found;
      data_out.error_position <= pos;
      data_out.uncorrectable  <= bad;
    end
  end

  assign data_out.valid = out_valid;

endmodule

// ===== test/tb_cyclic_code_encode_correct_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cyclic_code_encode_correct_core
// Self-checking bench for the cyclic code encoder / single-bit corrector.
// Drives encode and decode requests through the valid/ready channels, predicts
// each result from a GF(2) division written here, and compares field by field.
// Covers reset and programmed generators (including degenerate ones), random
// traffic with source gaps and sink stalls, and a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_cyclic_code_encode_correct_core;
  import ccec_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 190;

  localparam logic [ADDR_W-1:0] GEN_ADDR = ADDR_W'({REG_GEN, 2'b00});

  typedef struct packed {
    logic [CODE_LEN-1:0] codeword;
    logic [DATA_LEN-1:0] message;
    logic                found;
    logic [POS_W-1:0]    position;
    logic                bad;
  } code_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  ccec_in_if  in_ch ();
  ccec_out_if out_ch ();

  code_result_t     expected_q[$];
  logic [GEN_W-1:0] gen_reg = GEN_RESET;
  int unsigned      src_idle_pct = 0;
  int unsigned      snk_idle_pct = 0;
  int unsigned      mismatches = 0;
  int unsigned      stall_cycles = 0;
  bit               hold_armed = 1'b0;
  bit               hold_done = 1'b0;

  cyclic_code_encode_correct_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .data_in  (in_ch),
    .data_out (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // GF(2) remainder, using the true degree of the generator
  function automatic logic [CHECK_LEN-1:0] gf2_residue(logic [GEN_W-1:0] gen,
                                                       logic [CODE_LEN-1:0] dividend);
    int deg;
    int i;
    logic [CODE_LEN-1:0] acc;
    deg = -1;
    for (i = 0; i <= CHECK_LEN; i++) begin
      if (gen[i]) deg = i;
    end
    acc = dividend;
    if (deg >= 0) begin
      for (i = CODE_LEN - 1; i >= deg; i--) begin
        if (acc[i]) acc ^= CODE_LEN'(gen) << (i - deg);
      end
    end
    return acc[CHECK_LEN-1:0];
  endfunction

  function automatic code_result_t predict_result(logic op, logic [CODE_LEN-1:0] word,
                                                  logic [GEN_W-1:0] gen);
    code_result_t res;
    logic [CHECK_LEN-1:0] syndrome;
    logic [CODE_LEN-1:0] shifted;
    int i;
    bit hit;
    res = '0;
    if (op == OP_ENCODE) begin
      shifted = {word[DATA_LEN-1:0], {CHECK_LEN{1'b0}}};
      res.codeword = shifted ^ CODE_LEN'(gf2_residue(gen, shifted));
      res.message = word[DATA_LEN-1:0];
    end else begin
      res.codeword = word;
      syndrome = gf2_residue(gen, word);
      if (syndrome != '0) begin
        res.found = 1'b1;
        hit = 1'b0;
        // lowest matching position wins
        for (i = 0; i < CODE_LEN; i++) begin
          if (!hit && gf2_residue(gen, CODE_LEN'(1) << i) == syndrome) begin
            hit = 1'b1;
            res.codeword[i] = ~res.codeword[i];
            res.position = POS_W'(i);
          end
        end
        res.bad = !hit;
      end
      res.message = res.codeword[CODE_LEN-1:CHECK_LEN];
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    code_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        check_field("result with no request pending", 32'd0, 32'd1);
      end else begin
        want = expected_q.pop_front();
        check_field("codeword", 32'(want.codeword), 32'(out_ch.codeword));
        check_field("message_out", 32'(want.message), 32'(out_ch.message_out));
        check_field("error_found", 32'(want.found), 32'(out_ch.error_found));
        check_field("error_position", 32'(want.position), 32'(out_ch.error_position));
        check_field("uncorrectable", 32'(want.bad), 32'(out_ch.uncorrectable));
      end
    end
  end

  // watchdog: cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("cyclic_code_encode_correct_core regression: fail");
        $finish;
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_request(input logic op, input logic [CODE_LEN-1:0] word);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.word_in <= word;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_result(op, word, gen_reg));
  endtask

  // drop valid, wait for all results, then let the block go quiet
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_generator(input logic [GEN_W-1:0] value);
    logic [APB_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GEN_ADDR;
    pwdata  <= APB_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gen_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("generator readback", APB_W'(value), readback);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned flips;
    logic [CODE_LEN-1:0] word;
    code_result_t clean;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_request(OP_ENCODE, CODE_LEN'($urandom));
    end else if (pick < 85) begin
      // valid codeword with up to two flipped bits
      clean = predict_result(OP_ENCODE, CODE_LEN'($urandom), gen_reg);
      word = clean.codeword;
      flips = $urandom_range(2);
      repeat (flips) word[$urandom_range(CODE_LEN - 1)] ^= 1'b1;
      send_request(OP_DECODE, word);
    end else begin
      send_request(OP_DECODE, CODE_LEN'($urandom));
    end
  endtask

  task automatic run_random_phase(input logic [GEN_W-1:0] gen, input int unsigned src_pct,
                                  input int unsigned snk_pct, input int unsigned count);
    settle_block();
    write_generator(gen);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) send_random_request();
    settle_block();
  endtask

  // reset generator x^4+x+1, message extremes and ignored upper bits
  task automatic test_encode_edges();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_request(OP_ENCODE, 15'h0000);
    send_request(OP_ENCODE, 15'h07FF);
    send_request(OP_ENCODE, 15'h7FFF);
    send_request(OP_ENCODE, 15'h5555);
    settle_block();
  endtask

  task automatic test_decode_errors();
    code_result_t clean;
    logic [CODE_LEN-1:0] cw;
    clean = predict_result(OP_ENCODE, 15'h07FF, gen_reg);
    cw = clean.codeword;
    send_request(OP_DECODE, cw);
    send_request(OP_DECODE, cw ^ 15'h0001);
    send_request(OP_DECODE, cw ^ 15'h4000);
    send_request(OP_DECODE, cw ^ 15'h0080);
    send_request(OP_DECODE, cw ^ 15'h0003);
    send_request(OP_DECODE, 15'h7FFF);
    send_request(OP_DECODE, 15'h0000);
    settle_block();
  endtask

  // x^4+1: short cycle, so some syndromes never match and others match at three or four positions
  task automatic test_weak_generator();
    write_generator(5'd17);
    send_request(OP_DECODE, 15'h0003);
    send_request(OP_DECODE, 15'h0010);
    send_request(OP_ENCODE, 15'h02AA);
    settle_block();
  endtask

  // zero generator and generators of degree below CHECK_LEN
  task automatic test_degenerate_generators();
    write_generator(5'd0);
    send_request(OP_ENCODE, 15'h07FF);
    send_request(OP_DECODE, 15'h0005);
    send_request(OP_DECODE, 15'h0004);
    settle_block();
    write_generator(5'd3);
    send_request(OP_DECODE, 15'h4000);
    send_request(OP_ENCODE, 15'h0155);
    settle_block();
    write_generator(5'd11);
    send_request(OP_DECODE, 15'h0100);
    send_request(OP_ENCODE, 15'h07FF);
    settle_block();
  endtask

  task automatic test_random_traffic();
    run_random_phase(5'd19, 0, 0, PHASE_ITEMS);
    run_random_phase(5'd31, 87, 0, PHASE_ITEMS);
    run_random_phase(5'd17, 0, 87, PHASE_ITEMS);
    run_random_phase(5'd25, 31, 31, PHASE_ITEMS);
    run_random_phase(GEN_W'($urandom_range(31, 17)), 0, 0, PHASE_ITEMS);
    run_random_phase(5'd23, 87, 0, PHASE_ITEMS);
    run_random_phase(5'd29, 0, 87, PHASE_ITEMS);
    run_random_phase(GEN_W'($urandom_range(31, 0)), 31, 31, PHASE_ITEMS);
  endtask

  // sink holds off while the source keeps offering, so the input backs up
  task automatic test_output_backpressure();
    write_generator(5'd19);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_armed = 1'b1;
    repeat (12) send_random_request();
    settle_block();
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_ENCODE;
    in_ch.word_in = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    settle_block();

    test_encode_edges();
    test_decode_errors();
    test_weak_generator();
    test_degenerate_generators();
    test_random_traffic();
    test_output_backpressure();

    if (mismatches == 0) begin
      $display("cyclic_code_encode_correct_core regression: pass");
    end else begin
      $display("cyclic_code_encode_correct_core regression: fail");
    end
    $finish;
  end

endmodule
